### design/sotr_pkg.sv
// Shared types and constants for the slice occupancy bracket tracker.
`timescale 1ns / 1ps
package sotr_pkg;

  localparam int MAX_DIM  = 512;
  localparam int MAX_TIME = 4;
  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int TIME_W   = $clog2(MAX_TIME);
  localparam int ADDR_W   = DIM_W + TIME_W;
  localparam int DEPTH    = MAX_TIME * MAX_DIM;
  localparam int CNT_W    = 24;
  localparam int VAL_W    = 8;
  localparam int SIZE_W   = 10;
  localparam int NTS_W    = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NTS    = 2'd3;

  // request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // query axes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_RANGE    = 3'd1;
  localparam logic [2:0] STAT_OCCUPIED = 3'd2;
  localparam logic [2:0] STAT_NO_LOWER = 3'd3;
  localparam logic [2:0] STAT_NO_UPPER = 3'd4;

  typedef logic [ADDR_W-1:0] sotr_addr_t;
  typedef logic [CNT_W-1:0]  sotr_cnt_t;

  typedef struct packed {
    logic                    req_type;
    logic [TIME_W-1:0]       time_step;
    logic [DIM_W-1:0]        x_pos;
    logic [DIM_W-1:0]        y_pos;
    logic [DIM_W-1:0]        z_pos;
    logic signed [VAL_W-1:0] voxel_value;
    logic [1:0]              axis;
    logic [DIM_W-1:0]        query_index;
  } sotr_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DIM_W-1:0] lower_slice;
    logic [DIM_W-1:0] upper_slice;
  } sotr_out_t;

  typedef struct packed {
    logic       en;
    sotr_addr_t addr;
    sotr_cnt_t  data;
  } sotr_wr_t;

endpackage

### design/slice_occupancy_bracket_tracker.sv
// Top level of the slice occupancy bracket tracker.
`timescale 1ns / 1ps
// Usage
// - Input channel (in_valid_i / in_ready_o / in_data_i) takes one word at a time:
//   an update adds voxel_value to the x, y and z slice counters of its time step
//   (clamped at zero, saturating at 2^24-1); a query brackets an empty slice.
// - Output channel (out_valid_o / out_ready_i / out_data_o) carries one word per
//   query and none per update. The result sits in an output register, so updates
//   keep flowing while the receiver stalls; a second query result then waits in
//   the sequencer, with in_ready_o low, until that register is taken.
// - Updates read the counters on accept, then do the saturating add and write-back
//   from the registered memory read data. An update outside the volume in use is
//   dropped in its accept cycle.
// - Queries first read the queried slice, then the scan reads one slice per cycle
//   from the selected axis memory, first downward, then upward. Out-of-range
//   queries go straight to the result, occupied slices end after the first read.
//   The next word is taken in the cycle in which out_valid_o rises at the earliest.
// - Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is registered on cfg_we_i and
//   does not touch the counters.
// - After reset the three memories are cleared together, one entry per cycle, all
//   2048 entries, while in_ready_o stays low.
module slice_occupancy_bracket_tracker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  sotr_pkg::sotr_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output sotr_pkg::sotr_out_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [sotr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sotr_pkg::SIZE_W-1:0]           cfg_wdata_i
);
  import sotr_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_UPD   = 7'b0000100,
    ST_QCTR  = 7'b0001000,
    ST_QLO   = 7'b0010000,
    ST_QHI   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [NTS_W-1:0]  nts_q;

  // item and scan registers
  sotr_in_t          item_q, item_d;
  logic [SIZE_W-1:0] lim_q, lim_d;
  logic [DIM_W-1:0]  lo_q, lo_d;
  logic [DIM_W-1:0]  ptr_q, ptr_d;
  logic [DIM_W-1:0]  rd_idx_q, rd_idx_d;
  sotr_out_t         res_q, res_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  sotr_out_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  // memory ports
  sotr_wr_t   wr_x, wr_y, wr_z;
  sotr_addr_t rd_addr_x, rd_addr_y, rd_addr_z;
  sotr_cnt_t  rd_x, rd_y, rd_z, rd_sel;

  logic [DIM_W-1:0] scan_idx;

  logic [SIZE_W-1:0] eff_x, eff_y, eff_z, eff_q;
  logic [NTS_W-1:0]  eff_t;
  logic              upd_ok, qry_bad, accept;

  function automatic logic [SIZE_W-1:0] eff_dim(input logic [SIZE_W-1:0] s);
    eff_dim = (s > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : s;
  endfunction

  function automatic sotr_cnt_t sat_add(input sotr_cnt_t c,
                                        input logic signed [VAL_W-1:0] v);
    logic signed [CNT_W+1:0] s;
    s = $signed({2'b00, c}) + $signed({{(CNT_W+2-VAL_W){v[VAL_W-1]}}, v});
    if (s[CNT_W+1]) begin
      sat_add = '0;
    end else if (s[CNT_W]) begin
      sat_add = '1;
    end else begin
      sat_add = s[CNT_W-1:0];
    end
  endfunction

  assign eff_x = eff_dim(size_x_q);
  assign eff_y = eff_dim(size_y_q);
  assign eff_z = eff_dim(size_z_q);
  assign eff_t = (nts_q > NTS_W'(MAX_TIME)) ? NTS_W'(MAX_TIME) : nts_q;

  always_comb begin
    case (in_data_i.axis)
      AXIS_X:  eff_q = eff_x;
      AXIS_Y:  eff_q = eff_y;
      default: eff_q = eff_z;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign upd_ok = (NTS_W'(in_data_i.time_step) < eff_t) &&
                  (SIZE_W'(in_data_i.x_pos) < eff_x) &&
                  (SIZE_W'(in_data_i.y_pos) < eff_y) &&
                  (SIZE_W'(in_data_i.z_pos) < eff_z);

  assign qry_bad = (in_data_i.axis != AXIS_X && in_data_i.axis != AXIS_Y &&
                    in_data_i.axis != AXIS_Z) ||
                   (NTS_W'(in_data_i.time_step) >= eff_t) ||
                   (in_data_i.query_index == '0) ||
                   ((SIZE_W'(in_data_i.query_index) + SIZE_W'(1)) >= eff_q);

  always_comb begin
    case (item_q.axis)
      AXIS_X:  rd_sel = rd_x;
      AXIS_Y:  rd_sel = rd_y;
      default: rd_sel = rd_z;
    endcase
  end

  // scan read index; the first upward read is issued as the lower bound is found
  always_comb begin
    case (state_q)
      ST_QCTR: scan_idx = item_q.query_index - DIM_W'(1);
      ST_QLO:  scan_idx = (rd_sel != '0) ? item_q.query_index + DIM_W'(1) : ptr_q;
      default: scan_idx = ptr_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr_x = {in_data_i.time_step,
                   (in_data_i.req_type == REQ_QUERY) ? in_data_i.query_index
                                                     : in_data_i.x_pos};
      rd_addr_y = {in_data_i.time_step,
                   (in_data_i.req_type == REQ_QUERY) ? in_data_i.query_index
                                                     : in_data_i.y_pos};
      rd_addr_z = {in_data_i.time_step,
                   (in_data_i.req_type == REQ_QUERY) ? in_data_i.query_index
                                                     : in_data_i.z_pos};
    end else begin
      rd_addr_x = {item_q.time_step, scan_idx};
      rd_addr_y = {item_q.time_step, scan_idx};
      rd_addr_z = {item_q.time_step, scan_idx};
    end
  end

  // write ports: clearing pass or update write-back
  always_comb begin
    wr_x.en   = (state_q == ST_CLEAR) || (state_q == ST_UPD);
    wr_y.en   = wr_x.en;
    wr_z.en   = wr_x.en;
    if (state_q == ST_CLEAR) begin
      wr_x.addr = clr_q;
      wr_y.addr = clr_q;
      wr_z.addr = clr_q;
      wr_x.data = '0;
      wr_y.data = '0;
      wr_z.data = '0;
    end else begin
      wr_x.addr = {item_q.time_step, item_q.x_pos};
      wr_y.addr = {item_q.time_step, item_q.y_pos};
      wr_z.addr = {item_q.time_step, item_q.z_pos};
      wr_x.data = sat_add(rd_x, item_q.voxel_value);
      wr_y.data = sat_add(rd_y, item_q.voxel_value);
      wr_z.data = sat_add(rd_z, item_q.voxel_value);
    end
  end

  sotr_ram u_ram_x (
    .clk_i     (clk_i),
    .wr_i      (wr_x),
    .rd_addr_i (rd_addr_x),
    .rd_data_o (rd_x)
  );

  sotr_ram u_ram_y (
    .clk_i     (clk_i),
    .wr_i      (wr_y),
    .rd_addr_i (rd_addr_y),
    .rd_data_o (rd_y)
  );

  sotr_ram u_ram_z (
    .clk_i     (clk_i),
    .wr_i      (wr_z),
    .rd_addr_i (rd_addr_z),
    .rd_data_o (rd_z)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    lim_d    = lim_q;
    lo_d     = lo_q;
    ptr_d    = ptr_q;
    rd_idx_d = rd_idx_q;
    res_d    = res_q;
    clr_d    = clr_q;
    out_d    = out_q;
    out_vld_d = out_vld_q && !out_ready_i;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          lim_d  = eff_q;
          if (in_data_i.req_type == REQ_UPDATE) begin
            if (upd_ok) begin
              state_d = ST_UPD;
            end
          end else if (qry_bad) begin
            res_d   = '{status: STAT_RANGE, lower_slice: '0, upper_slice: '0};
            state_d = ST_DONE;
          end else begin
            state_d = ST_QCTR;
          end
        end
      end
      ST_UPD: begin
        state_d = ST_IDLE;
      end
      ST_QCTR: begin
        rd_idx_d = scan_idx;
        ptr_d    = scan_idx - DIM_W'(1);
        if (rd_sel != '0) begin
          res_d   = '{status: STAT_OCCUPIED, lower_slice: '0, upper_slice: '0};
          state_d = ST_DONE;
        end else begin
          state_d = ST_QLO;
        end
      end
      ST_QLO: begin
        rd_idx_d = scan_idx;
        if (rd_sel != '0) begin
          lo_d    = rd_idx_q;
          ptr_d   = scan_idx + DIM_W'(1);
          state_d = ST_QHI;
        end else if (rd_idx_q == '0) begin
          res_d   = '{status: STAT_NO_LOWER, lower_slice: '0, upper_slice: '0};
          state_d = ST_DONE;
        end else begin
          ptr_d = ptr_q - DIM_W'(1);
        end
      end
      ST_QHI: begin
        rd_idx_d = scan_idx;
        ptr_d    = ptr_q + DIM_W'(1);
        if (rd_sel != '0) begin
          res_d   = '{status: STAT_OK, lower_slice: lo_q, upper_slice: rd_idx_q};
          state_d = ST_DONE;
        end else if ((SIZE_W'(rd_idx_q) + SIZE_W'(1)) >= lim_q) begin
          res_d   = '{status: STAT_NO_UPPER, lower_slice: '0, upper_slice: '0};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or being emptied
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    lim_q    <= lim_d;
    lo_q     <= lo_d;
    ptr_q    <= ptr_d;
    rd_idx_q <= rd_idx_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_W'(MAX_DIM);
      size_y_q <= SIZE_W'(MAX_DIM);
      size_z_q <= SIZE_W'(MAX_DIM);
      nts_q    <= NTS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        CFG_NTS:    nts_q    <= cfg_wdata_i[NTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### design/sotr_ram.sv
// Counter store: one write port, one registered read port.
`timescale 1ns / 1ps
module sotr_ram (
  input  logic             clk_i,
  input  sotr_pkg::sotr_wr_t   wr_i,
  input  sotr_pkg::sotr_addr_t rd_addr_i,
  output sotr_pkg::sotr_cnt_t  rd_data_o
);
  import sotr_pkg::*;

  sotr_cnt_t mem_q [DEPTH];
  sotr_cnt_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### tb/slice_occupancy_bracket_tracker_tb.sv
// Self-checking testbench for the slice occupancy bracket tracker.
`timescale 1ns / 1ps
module slice_occupancy_bracket_tracker_tb;
  import sotr_pkg::*;

  // Axis code outside the three real axes; the block must flag it as out of range.
  localparam logic [1:0] AXIS_BAD = 2'd3;

  localparam int CNT_TOP     = (1 << CNT_W) - 1;
  localparam int SETTLE      = 8;      // cycles for an update still in flight
  localparam int STALL_LIMIT = 20000;  // covers the clearing pass and a full scan
  localparam int RND_TOTAL   = 1300;   // random words over all geometry phases

  // Directed stimulus rows: a word, plus a typed-in result where it is obvious.
  typedef struct packed {
    sotr_in_t  word;
    bit        typed;
    sotr_out_t res;
  } probe_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  sotr_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  sotr_out_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_wdata_i = '0;

  slice_occupancy_bracket_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: slice counters per axis, geometry registers as written.
  // ---------------------------------------------------------------------------
  sotr_cnt_t         slice_count [3][DEPTH] = '{default: '0};
  logic [SIZE_W-1:0] span [3] = '{10'd512, 10'd512, 10'd512};
  logic [NTS_W-1:0]  steps_in_use = 3'd1;

  sotr_out_t expected_brackets [$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rnd_done      = 0;
  int stall_cycles  = 0;

  probe_row_t probe_tab [24];

  // A size above MAX_DIM behaves as MAX_DIM; likewise the time step count.
  function automatic int unsigned usable(logic [SIZE_W-1:0] s);
    return (s > MAX_DIM) ? MAX_DIM : s;
  endfunction

  function automatic int unsigned live_steps();
    return (steps_in_use > MAX_TIME) ? MAX_TIME : steps_in_use;
  endfunction

  // Voxel change: all three slice counters move together, clamped to
  // [0, 2^24-1]; anything outside the volume in use is dropped whole.
  function automatic void tally_voxel(sotr_in_t w);
    int unsigned      base;
    logic [DIM_W-1:0] pos [3];
    int               v;
    if (w.time_step >= live_steps()) return;
    pos = '{w.x_pos, w.y_pos, w.z_pos};
    for (int a = 0; a < 3; a++)
      if (pos[a] >= usable(span[a])) return;
    base = w.time_step * MAX_DIM;
    for (int a = 0; a < 3; a++) begin
      v = int'(slice_count[a][base + pos[a]]) + int'($signed(w.voxel_value));
      if (v < 0) v = 0;
      if (v > CNT_TOP) v = CNT_TOP;
      slice_count[a][base + pos[a]] = sotr_cnt_t'(v);
    end
  endfunction

  // Bracket query: interior and empty slice, then nearest occupied below/above.
  function automatic sotr_out_t bracket_of(sotr_in_t w);
    sotr_out_t   r;
    int unsigned lim;
    int unsigned base;
    int unsigned q;
    int          lo;
    int          hi;
    r = '{status: STAT_RANGE, lower_slice: '0, upper_slice: '0};
    if (w.axis > AXIS_Z) return r;
    if (w.time_step >= live_steps()) return r;
    lim = usable(span[w.axis]);
    q = w.query_index;
    if (q < 1 || q + 1 >= lim) return r;
    base = w.time_step * MAX_DIM;
    if (slice_count[w.axis][base + q] != 0) begin
      r.status = STAT_OCCUPIED;
      return r;
    end
    lo = -1;
    for (int i = int'(q) - 1; i >= 0 && lo < 0; i--)
      if (slice_count[w.axis][base + i] != 0) lo = i;
    if (lo < 0) begin
      r.status = STAT_NO_LOWER;
      return r;
    end
    hi = -1;
    for (int i = int'(q) + 1; i < int'(lim) && hi < 0; i++)
      if (slice_count[w.axis][base + i] != 0) hi = i;
    if (hi < 0) begin
      r.status = STAT_NO_UPPER;
      return r;
    end
    r.status      = STAT_OK;
    r.lower_slice = DIM_W'(lo);
    r.upper_slice = DIM_W'(hi);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders for the directed table and the closing run.
  // ---------------------------------------------------------------------------
  function automatic probe_row_t upd_row(int t, int x, int y, int z, int v);
    probe_row_t r;
    r = '0;
    r.word.req_type    = REQ_UPDATE;
    r.word.time_step   = TIME_W'(t);
    r.word.x_pos       = DIM_W'(x);
    r.word.y_pos       = DIM_W'(y);
    r.word.z_pos       = DIM_W'(z);
    r.word.voxel_value = VAL_W'(v);
    return r;
  endfunction

  function automatic probe_row_t qry_row(int t, logic [1:0] ax, int q);
    probe_row_t r;
    r = '0;
    r.word.req_type    = REQ_QUERY;
    r.word.time_step   = TIME_W'(t);
    r.word.axis        = ax;
    r.word.query_index = DIM_W'(q);
    return r;
  endfunction

  // Query whose status can be read straight off; slice fields stay zero.
  function automatic probe_row_t qry_says(int t, logic [1:0] ax, int q, logic [2:0] st);
    probe_row_t r;
    r = qry_row(t, ax, q);
    r.typed      = 1'b1;
    r.res.status = st;
    return r;
  endfunction

  // Random word shaped by the current geometry: mostly in-volume updates and
  // interior queries, with a slice of fully random noise words.
  function automatic sotr_in_t rand_word();
    sotr_in_t    w;
    logic [63:0] raw;
    int unsigned lim;
    int unsigned nt;
    raw = {$urandom, $urandom};
    w = raw[$bits(sotr_in_t)-1:0];
    if ($urandom_range(0, 99) < 8) return w;
    nt = live_steps();
    if (nt > 0) w.time_step = TIME_W'($urandom_range(0, nt - 1));
    if ($urandom_range(0, 99) < 70) begin
      w.req_type = REQ_UPDATE;
      lim = usable(span[0]);
      if (lim > 0) w.x_pos = DIM_W'($urandom_range(0, lim - 1));
      lim = usable(span[1]);
      if (lim > 0) w.y_pos = DIM_W'($urandom_range(0, lim - 1));
      lim = usable(span[2]);
      if (lim > 0) w.z_pos = DIM_W'($urandom_range(0, lim - 1));
      // small steps keep counters hovering around zero, so slices empty again
      if ($urandom_range(0, 1)) w.voxel_value = VAL_W'(int'($urandom_range(0, 8)) - 4);
    end else begin
      w.req_type = REQ_QUERY;
      w.axis = 2'($urandom_range(0, 2));
      lim = usable(span[w.axis]);
      if (lim >= 3) w.query_index = DIM_W'($urandom_range(1, lim - 2));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side.
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then fold it into the shadow.
  task automatic push_word(input sotr_in_t w, input bit typed, input sotr_out_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.req_type == REQ_UPDATE) tally_voxel(w);
    else expected_brackets.push_back(typed ? typed_res : bracket_of(w));
  endtask

  // Let every outstanding query answer and any trailing update retire.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_brackets.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                              input logic [SIZE_W-1:0] sz, input logic [SIZE_W-1:0] nt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SIZE_X;
    cfg_wdata_i <= sx;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIZE_Y;
    cfg_wdata_i <= sy;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIZE_Z;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NTS;
    cfg_wdata_i <= nt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    span         = '{sx, sy, sz};
    steps_in_use = nt[NTS_W-1:0];
  endtask

  // Pacing follows the position in the random run: receiver-heavy stalls,
  // then sender-heavy gaps, then full rate.
  task automatic run_random(input int n);
    repeat (n) begin
      case (rnd_done * 3 / RND_TOTAL)
        0:       begin send_idle_pct = 12; recv_idle_pct = 62; end
        1:       begin send_idle_pct = 62; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      push_word(rand_word(), 1'b0, '0);
      rnd_done++;
    end
  endtask

  task automatic pump_voxel(input int n, input int v);
    probe_row_t r;
    r = upd_row(3, 2, 2, 2, v);
    repeat (n) push_word(r.word, 1'b0, '0);
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    sotr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_brackets.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got status %0d lower %0d upper %0d",
                 $time, out_data_o.status, out_data_o.lower_slice, out_data_o.upper_slice);
      end else begin
        want = expected_brackets.pop_front();
        check_field("status", want.status, out_data_o.status);
        check_field("lower_slice", want.lower_slice, out_data_o.lower_slice);
        check_field("upper_slice", want.upper_slice, out_data_o.upper_slice);
      end
    end
  end

  // Watchdog: a run of cycles with no word moving on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("slice_occupancy_bracket_tracker test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed words under the reset geometry (512 per axis, one time step).
    probe_tab = '{
      qry_says(0, AXIS_X, 5, STAT_NO_LOWER),      // empty store
      qry_says(0, AXIS_X, 0, STAT_RANGE),         // bottom edge slice
      qry_says(0, AXIS_Y, 511, STAT_RANGE),       // top edge slice
      qry_says(0, AXIS_Z, 510, STAT_NO_LOWER),    // highest interior slice
      qry_says(0, AXIS_BAD, 100, STAT_RANGE),     // no such axis
      qry_says(1, AXIS_X, 100, STAT_RANGE),       // time step not in use
      upd_row(1, 10, 10, 10, 50),                 // dropped: time step not in use
      qry_says(0, AXIS_X, 10, STAT_NO_LOWER),
      upd_row(0, 10, 20, 30, 127),
      upd_row(0, 10, 20, 30, -128),               // clamps back to zero
      qry_row(0, AXIS_Y, 20),
      upd_row(0, 0, 0, 0, 5),
      upd_row(0, 511, 511, 511, 1),
      qry_row(0, AXIS_X, 256),                    // widest bracket
      qry_row(0, AXIS_Z, 1),
      qry_row(0, AXIS_Y, 510),
      upd_row(0, 300, 300, 300, -1),              // decrement of an empty slice
      qry_row(0, AXIS_X, 300),
      upd_row(0, 100, 200, 400, 3),
      qry_says(0, AXIS_X, 100, STAT_OCCUPIED),
      upd_row(0, 511, 511, 511, -1),
      qry_row(0, AXIS_X, 256),
      qry_row(0, AXIS_Z, 450),
      upd_row(3, 511, 511, 511, -128)             // dropped: time step not in use
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 62;
    foreach (probe_tab[i]) push_word(probe_tab[i].word, probe_tab[i].typed, probe_tab[i].res);
    drain();

    // Oversized registers: sizes act as 512 and the step count as four.
    set_geometry(10'd1023, 10'd700, 10'd512, 10'd7);
    run_random(400);
    drain();

    // Tiny volume: edges, empty neighbours and missing brackets dominate.
    set_geometry(10'd3, 10'd4, 10'd5, 10'd2);
    run_random(300);
    drain();

    // Degenerate volume: nothing is in range at all.
    set_geometry(10'd0, 10'd1, 10'd2, 10'd0);
    run_random(150);
    drain();

    set_geometry(10'd40, 10'd17, 10'd64, 10'd4);
    run_random(RND_TOTAL - 850);
    drain();

    // Full rate on the last time step; upper bits of the step count are dropped.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(10'd512, 10'd512, 10'd512, 10'h3FC);
    pump_voxel(3, 127);
    push_word(qry_row(3, AXIS_X, 2).word, 1'b0, '0);
    pump_voxel(2, -128);
    pump_voxel(1, -124);
    push_word(qry_row(3, AXIS_Y, 2).word, 1'b0, '0);   // one vote left
    pump_voxel(1, -1);
    push_word(qry_row(3, AXIS_Z, 2).word, 1'b0, '0);   // now empty
    push_word(qry_row(3, AXIS_X, 2).word, 1'b0, '0);
    drain();

    if (mismatches == 0)
      $display("slice_occupancy_bracket_tracker test passed");
    else
      $display("slice_occupancy_bracket_tracker test failed");
    $finish;
  end

endmodule
